@@ hdl/tdhg_pkg.sv @@
package tdhg_pkg;

	localparam int unsigned ModeW   = 3;
	localparam int unsigned CountW  = 4;
	localparam int unsigned CoordW  = 16;
	localparam int unsigned TicksW  = 16;
	localparam int unsigned RadiusW = 17;
	localparam int unsigned CodeW   = 3;
	localparam int unsigned CfgW    = 17;
	localparam int unsigned CfgIdxW = 1;

	localparam logic [ModeW-1:0] MODE_BEGIN  = 3'd0;
	localparam logic [ModeW-1:0] MODE_UPDATE = 3'd1;
	localparam logic [ModeW-1:0] MODE_END    = 3'd2;
	localparam logic [ModeW-1:0] MODE_TICK   = 3'd3;
	localparam logic [ModeW-1:0] MODE_CLEAR  = 3'd4;

	localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_TAP_RADIUS = 1'd1;

	localparam logic [TicksW-1:0]  HOLD_TICKS_RST = 16'd700;
	localparam logic [RadiusW-1:0] TAP_RADIUS_RST = 17'd40;

	localparam logic [CountW-1:0] ONE_TOUCH = 4'd1;

	typedef enum logic [CodeW-1:0] {
		RC_IGNORE  = 3'd0,
		RC_MAYBE   = 3'd1,
		RC_TRIGGER = 3'd2,
		RC_FINISH  = 3'd3,
		RC_CANCEL  = 3'd4
	} result_t;

	typedef enum logic [1:0] {
		KIND_UNDEF = 2'd0,
		KIND_TAP   = 2'd1,
		KIND_HOLD  = 2'd2,
		KIND_DRAG  = 2'd3
	} kind_t;

endpackage

@@ hdl/tap_drag_hold_gesture_detector.sv @@
// Channel | Handshake                     | Payload
// in      | in_valid / in_ready           | mode, touch_count, pos_*, start_*, screen_*
// out     | out_valid / out_ready         | result_code, consume_hint, gesture_kind,
//         |                               | cur_*, hot_*
// cfg     | cfg_we (no wait)              | cfg_index, cfg_data
//
// One item per cycle without stalls; an item passes input, then result register.
// The input register feeds the gesture update and the result register directly.
// arst_n clears the gesture state, the registers to 700 / 40 and both valid flags.
// A stalled result holds the item in the input register and alone drops in_ready.
module tap_drag_hold_gesture_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tdhg_pkg::ModeW-1:0]    mode,
	input  logic [tdhg_pkg::CountW-1:0]   touch_count,
	input  logic signed [tdhg_pkg::CoordW-1:0] pos_x,
	input  logic signed [tdhg_pkg::CoordW-1:0] pos_y,
	input  logic signed [tdhg_pkg::CoordW-1:0] start_x,
	input  logic signed [tdhg_pkg::CoordW-1:0] start_y,
	input  logic signed [tdhg_pkg::CoordW-1:0] screen_x,
	input  logic signed [tdhg_pkg::CoordW-1:0] screen_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tdhg_pkg::CodeW-1:0]    result_code,
	output logic                          consume_hint,
	output logic [1:0]                    gesture_kind,
	output logic signed [tdhg_pkg::CoordW-1:0] cur_x,
	output logic signed [tdhg_pkg::CoordW-1:0] cur_y,
	output logic signed [tdhg_pkg::CoordW-1:0] hot_x,
	output logic signed [tdhg_pkg::CoordW-1:0] hot_y,
	input  logic                          cfg_we,
	input  logic [tdhg_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [tdhg_pkg::CfgW-1:0]     cfg_data
);
	import tdhg_pkg::*;

	logic                     valid_s1;
	logic [ModeW-1:0]         mode_s1;
	logic [CountW-1:0]        count_s1;
	logic signed [CoordW-1:0] pos_x_s1, pos_y_s1, start_x_s1, start_y_s1;
	logic signed [CoordW-1:0] scr_x_s1, scr_y_s1;

	logic [TicksW-1:0]  hold_ticks_q;
	logic [RadiusW-1:0] tap_radius_q;

	kind_t              kind_q;
	logic               timer_on_q;
	logic [TicksW-1:0]  ticks_q;
	logic signed [CoordW-1:0] place_x_q, place_y_q, spot_x_q, spot_y_q;

	logic               out_valid_q;
	result_t            res_code_q;
	logic               consume_q;

	logic               advance;
	logic signed [CoordW:0] diff_x, diff_y;
	logic [CoordW:0]    abs_x, abs_y;
	logic [CoordW+1:0]  manh_sum;
	logic               is_drag;

	kind_t              kind_d;
	logic               timer_on_d;
	logic [TicksW-1:0]  ticks_d;
	logic               take_pt;
	logic               clear_all;
	result_t            rc_d;
	logic               consume_d;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1    <= mode;
			count_s1   <= touch_count;
			pos_x_s1   <= pos_x;
			pos_y_s1   <= pos_y;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			scr_x_s1   <= screen_x;
			scr_y_s1   <= screen_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_TICKS_RST;
			tap_radius_q <= TAP_RADIUS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOLD_TICKS: hold_ticks_q <= cfg_data[TicksW-1:0];
				REG_TAP_RADIUS: tap_radius_q <= cfg_data[RadiusW-1:0];
				default: ;
			endcase
		end
	end

	assign diff_x  = {pos_x_s1[CoordW-1], pos_x_s1} - {start_x_s1[CoordW-1], start_x_s1};
	assign diff_y  = {pos_y_s1[CoordW-1], pos_y_s1} - {start_y_s1[CoordW-1], start_y_s1};
	assign abs_x   = diff_x[CoordW] ? (CoordW+1)'(-diff_x) : diff_x;
	assign abs_y   = diff_y[CoordW] ? (CoordW+1)'(-diff_y) : diff_y;
	assign manh_sum = {1'b0, abs_x} + {1'b0, abs_y};
	assign is_drag = manh_sum > {1'b0, tap_radius_q};

	always_comb begin
		kind_d     = kind_q;
		timer_on_d = timer_on_q;
		ticks_d    = ticks_q;
		take_pt    = 1'b0;
		clear_all  = 1'b0;
		rc_d       = RC_IGNORE;
		consume_d  = 1'b0;
		case (mode_s1)
			MODE_BEGIN: begin
				take_pt    = 1'b1;
				timer_on_d = 1'b1;
				ticks_d    = hold_ticks_q;
				rc_d       = RC_MAYBE;
			end
			MODE_UPDATE: begin
				if (timer_on_q && count_s1 == ONE_TOUCH) begin
					take_pt = 1'b1;
					if (is_drag) begin
						kind_d = KIND_DRAG;
						rc_d   = RC_TRIGGER;
					end else begin
						kind_d = KIND_TAP;
						rc_d   = RC_MAYBE;
					end
				end else begin
					rc_d = RC_CANCEL;
				end
			end
			MODE_END: begin
				if (count_s1 != ONE_TOUCH) begin
					rc_d = RC_CANCEL;
				end else if (!timer_on_q) begin
					rc_d = RC_IGNORE;
				end else if (kind_q == KIND_UNDEF) begin
					kind_d = KIND_TAP;
					rc_d   = RC_FINISH;
				end else if (kind_q == KIND_HOLD) begin
					rc_d = RC_CANCEL;
				end else begin
					take_pt = 1'b1;
					rc_d    = RC_FINISH;
				end
			end
			MODE_TICK: begin
				if (timer_on_q) begin
					if (ticks_q <= TicksW'(1)) begin
						if (kind_q == KIND_DRAG) begin
							ticks_d = hold_ticks_q;
						end else begin
							timer_on_d = 1'b0;
							ticks_d    = '0;
							kind_d     = KIND_HOLD;
							rc_d       = RC_FINISH;
							consume_d  = 1'b1;
						end
					end else begin
						ticks_d = ticks_q - TicksW'(1);
					end
				end
			end
			MODE_CLEAR: begin
				clear_all  = 1'b1;
				kind_d     = KIND_UNDEF;
				timer_on_d = 1'b0;
				ticks_d    = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= KIND_UNDEF;
			timer_on_q <= 1'b0;
			ticks_q    <= '0;
			place_x_q  <= '0;
			place_y_q  <= '0;
			spot_x_q   <= '0;
			spot_y_q   <= '0;
		end else if (advance) begin
			kind_q     <= kind_d;
			timer_on_q <= timer_on_d;
			ticks_q    <= ticks_d;
			if (clear_all) begin
				place_x_q <= '0;
				place_y_q <= '0;
				spot_x_q  <= '0;
				spot_y_q  <= '0;
			end else if (take_pt) begin
				place_x_q <= pos_x_s1;
				place_y_q <= pos_y_s1;
				spot_x_q  <= scr_x_s1;
				spot_y_q  <= scr_y_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_code_q <= rc_d;
			consume_q  <= consume_d;
		end
	end

	// state registers already hold the post-item snapshot while the result waits
	assign out_valid    = out_valid_q;
	assign result_code  = res_code_q;
	assign consume_hint = consume_q;
	assign gesture_kind = kind_q;
	assign cur_x        = place_x_q;
	assign cur_y        = place_y_q;
	assign hot_x        = spot_x_q;
	assign hot_y        = spot_y_q;

`ifndef SYNTHESIS
	a_consume_is_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && consume_hint |-> result_code == RC_FINISH && gesture_kind == KIND_HOLD)
		else $error("consume without hold finish");
	a_trigger_is_drag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_code == RC_TRIGGER |-> gesture_kind == KIND_DRAG)
		else $error("trigger without drag");
	a_timer_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!timer_on_q |-> ticks_q == '0)
		else $error("idle timer holds a count");
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(kind_q) && $stable(ticks_q))
		else $error("state moved under a stalled result");
`endif

endmodule

@@ dv/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tdhg_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SHOW_LIMIT  = 40;

	localparam logic [ModeW-1:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [ModeW-1:0] MODE_SPARE_MID = 3'd6;
	localparam logic [ModeW-1:0] MODE_SPARE_HI  = 3'd7;

	localparam logic signed [CoordW-1:0] COORD_MIN = 16'sh8000;
	localparam logic signed [CoordW-1:0] COORD_MAX = 16'sh7fff;

	localparam logic [CfgW-1:0] RADIUS_FULL  = 17'd131070;
	localparam logic [CfgW-1:0] RADIUS_ONES  = 17'h1ffff;
	localparam logic [CfgW-1:0] HOLD_ONES    = 17'h0ffff;
	localparam logic [CfgW-1:0] HOLD_HIGHBIT = 17'h10004;

	typedef struct {
		logic [ModeW-1:0]         mode;
		logic [CountW-1:0]        count;
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic signed [CoordW-1:0] start_x;
		logic signed [CoordW-1:0] start_y;
		logic signed [CoordW-1:0] scr_x;
		logic signed [CoordW-1:0] scr_y;
	} touch_t;

	typedef struct {
		result_t                  code;
		logic                     consume;
		kind_t                    kind;
		logic signed [CoordW-1:0] cur_x;
		logic signed [CoordW-1:0] cur_y;
		logic signed [CoordW-1:0] hot_x;
		logic signed [CoordW-1:0] hot_y;
	} gesture_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [ModeW-1:0]         mode = MODE_CLEAR;
	logic [CountW-1:0]        touch_count = '0;
	logic signed [CoordW-1:0] pos_x = '0;
	logic signed [CoordW-1:0] pos_y = '0;
	logic signed [CoordW-1:0] start_x = '0;
	logic signed [CoordW-1:0] start_y = '0;
	logic signed [CoordW-1:0] screen_x = '0;
	logic signed [CoordW-1:0] screen_y = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [CodeW-1:0]         result_code;
	logic                     consume_hint;
	logic [1:0]               gesture_kind;
	logic signed [CoordW-1:0] cur_x;
	logic signed [CoordW-1:0] cur_y;
	logic signed [CoordW-1:0] hot_x;
	logic signed [CoordW-1:0] hot_y;
	logic                     cfg_we = 1'b0;
	logic [CfgIdxW-1:0]       cfg_index = REG_HOLD_TICKS;
	logic [CfgW-1:0]          cfg_data = '0;

	tap_drag_hold_gesture_detector dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.touch_count  (touch_count),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.start_x      (start_x),
		.start_y      (start_y),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_code  (result_code),
		.consume_hint (consume_hint),
		.gesture_kind (gesture_kind),
		.cur_x        (cur_x),
		.cur_y        (cur_y),
		.hot_x        (hot_x),
		.hot_y        (hot_y),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// gesture state mirror
	logic [TicksW-1:0]        hold_setting = HOLD_TICKS_RST;
	logic [RadiusW-1:0]       radius_setting = TAP_RADIUS_RST;
	kind_t                    g_kind = KIND_UNDEF;
	logic                     g_timer_on = 1'b0;
	logic [TicksW-1:0]        g_ticks_left = '0;
	logic signed [CoordW-1:0] g_place_x = '0;
	logic signed [CoordW-1:0] g_place_y = '0;
	logic signed [CoordW-1:0] g_spot_x = '0;
	logic signed [CoordW-1:0] g_spot_y = '0;

	gesture_t    pending_results[$];
	int unsigned mismatches = 0;
	int unsigned sent_items = 0;
	int unsigned cycle_count = 0;
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;

	function automatic int unsigned coord_gap(logic signed [CoordW-1:0] a,
			logic signed [CoordW-1:0] b);
		int d;
		d = int'(a) - int'(b);
		return (d < 0) ? -d : d;
	endfunction

	function automatic void take_point(touch_t t);
		g_place_x = t.pos_x;
		g_place_y = t.pos_y;
		g_spot_x = t.scr_x;
		g_spot_y = t.scr_y;
	endfunction

	function automatic gesture_t step_gesture(touch_t t);
		gesture_t r;
		int unsigned gap_sum;
		r.code = RC_IGNORE;
		r.consume = 1'b0;
		case (t.mode)
			MODE_BEGIN: begin
				take_point(t);
				g_timer_on = 1'b1;
				g_ticks_left = hold_setting;
				r.code = RC_MAYBE;
			end
			MODE_UPDATE: begin
				if (g_timer_on && t.count == ONE_TOUCH) begin
					take_point(t);
					gap_sum = coord_gap(t.pos_x, t.start_x) + coord_gap(t.pos_y, t.start_y);
					if (gap_sum > int'(radius_setting)) begin
						g_kind = KIND_DRAG;
						r.code = RC_TRIGGER;
					end else begin
						g_kind = KIND_TAP;
						r.code = RC_MAYBE;
					end
				end else begin
					r.code = RC_CANCEL;
				end
			end
			MODE_END: begin
				if (t.count != ONE_TOUCH) begin
					r.code = RC_CANCEL;
				end else if (!g_timer_on) begin
					r.code = RC_IGNORE;
				end else if (g_kind == KIND_UNDEF) begin
					g_kind = KIND_TAP;
					r.code = RC_FINISH;
				end else if (g_kind == KIND_HOLD) begin
					r.code = RC_CANCEL;
				end else begin
					take_point(t);
					r.code = RC_FINISH;
				end
			end
			MODE_TICK: begin
				if (g_timer_on) begin
					if (g_ticks_left <= 1) begin
						g_ticks_left = hold_setting;
						if (g_kind != KIND_DRAG) begin
							g_timer_on = 1'b0;
							g_ticks_left = '0;
							g_kind = KIND_HOLD;
							r.code = RC_FINISH;
							r.consume = 1'b1;
						end
					end else begin
						g_ticks_left = g_ticks_left - 1'b1;
					end
				end
			end
			MODE_CLEAR: begin
				g_kind = KIND_UNDEF;
				g_timer_on = 1'b0;
				g_ticks_left = '0;
				g_place_x = '0;
				g_place_y = '0;
				g_spot_x = '0;
				g_spot_y = '0;
			end
			default: ;
		endcase
		r.kind = g_kind;
		r.cur_x = g_place_x;
		r.cur_y = g_place_y;
		r.hot_x = g_spot_x;
		r.hot_y = g_spot_y;
		return r;
	endfunction

	function automatic touch_t make_event(logic [ModeW-1:0] m, logic [CountW-1:0] n,
			logic signed [CoordW-1:0] px, logic signed [CoordW-1:0] py,
			logic signed [CoordW-1:0] sx, logic signed [CoordW-1:0] sy,
			logic signed [CoordW-1:0] hx, logic signed [CoordW-1:0] hy);
		touch_t t;
		t.mode = m;
		t.count = n;
		t.pos_x = px;
		t.pos_y = py;
		t.start_x = sx;
		t.start_y = sy;
		t.scr_x = hx;
		t.scr_y = hy;
		return t;
	endfunction

	function automatic touch_t noise_event();
		return make_event(ModeW'($urandom_range(0, 7)), CountW'($urandom_range(0, 15)),
			CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
			CoordW'($urandom), CoordW'($urandom));
	endfunction

	function automatic logic [CountW-1:0] pick_count(int unsigned one_pct);
		if ($urandom_range(0, 99) < one_pct)
			return ONE_TOUCH;
		return CountW'($urandom_range(0, 15));
	endfunction

	// land near the tap radius so both sides of the threshold are hit
	function automatic touch_t moved_event(logic [ModeW-1:0] m, logic [CountW-1:0] n,
			logic signed [CoordW-1:0] sx, logic signed [CoordW-1:0] sy);
		int unsigned target;
		int unsigned dx;
		int unsigned dy;
		logic signed [CoordW-1:0] px;
		logic signed [CoordW-1:0] py;
		if (radius_setting > 2000 || $urandom_range(0, 6) == 0) begin
			px = CoordW'($urandom);
			py = CoordW'($urandom);
		end else begin
			target = radius_setting + $urandom_range(0, 4);
			target = (target >= 2) ? target - 2 : 0;
			dx = $urandom_range(0, target);
			dy = target - dx;
			px = $urandom_range(0, 1) ? sx + CoordW'(dx) : sx - CoordW'(dx);
			py = $urandom_range(0, 1) ? sy + CoordW'(dy) : sy - CoordW'(dy);
		end
		return make_event(m, n, px, py, sx, sy, CoordW'($urandom), CoordW'($urandom));
	endfunction

	task automatic send_event(touch_t t);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= t.mode;
		touch_count <= t.count;
		pos_x <= t.pos_x;
		pos_y <= t.pos_y;
		start_x <= t.start_x;
		start_y <= t.start_y;
		screen_x <= t.scr_x;
		screen_y <= t.scr_y;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(step_gesture(t));
		sent_items++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HOLD_TICKS)
			hold_setting = data[TicksW-1:0];
		else
			radius_setting = data[RadiusW-1:0];
		@(negedge clk);
	endtask

	task automatic set_regs(logic [CfgW-1:0] hold, logic [CfgW-1:0] radius);
		drain_results();
		write_reg(REG_HOLD_TICKS, hold);
		write_reg(REG_TAP_RADIUS, radius);
	endtask

	task automatic cmp_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		gesture_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t unexpected item: expected none actual code %0d",
					$time, result_code);
			end else begin
				want = pending_results.pop_front();
				cmp_field("result_code", int'(want.code), int'(result_code));
				cmp_field("consume_hint", int'(want.consume), int'(consume_hint));
				cmp_field("gesture_kind", int'(want.kind), int'(gesture_kind));
				cmp_field("cur_x", int'(want.cur_x), int'(cur_x));
				cmp_field("cur_y", int'(want.cur_y), int'(cur_y));
				cmp_field("hot_x", int'(want.hot_x), int'(hot_x));
				cmp_field("hot_y", int'(want.hot_y), int'(hot_y));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		@(negedge clk);
		forever begin
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
		end
	end

	task automatic test_default_regs();
		gap_pct = 20;
		stall_pct = 20;
		send_event(make_event(MODE_SPARE_LO, ONE_TOUCH, 1, 2, 3, 4, 5, 6));
		send_event(make_event(MODE_SPARE_HI, 4'd15, -1, -1, -1, -1, -1, -1));
		send_event(make_event(MODE_TICK, ONE_TOUCH, 7, 7, 7, 7, 7, 7));
		send_event(make_event(MODE_UPDATE, ONE_TOUCH, 9, 9, 0, 0, 9, 9));
		send_event(make_event(MODE_END, ONE_TOUCH, 9, 9, 0, 0, 9, 9));
		send_event(make_event(MODE_BEGIN, 4'd0, 100, 100, 100, 100, 1000, -1000));
		send_event(make_event(MODE_UPDATE, ONE_TOUCH, 125, 85, 100, 100, 1025, -985));
		send_event(make_event(MODE_UPDATE, ONE_TOUCH, 126, 85, 100, 100, 1026, -985));
		send_event(make_event(MODE_UPDATE, 4'd2, 130, 85, 100, 100, 1030, -985));
		send_event(make_event(MODE_END, ONE_TOUCH, 140, 60, 100, 100, 1040, -960));
		send_event(make_event(MODE_END, 4'd0, 150, 50, 100, 100, 1050, -950));
		send_event(make_event(MODE_CLEAR, ONE_TOUCH, 1, 1, 1, 1, 1, 1));
	endtask

	task automatic test_register_extremes();
		set_regs('0, RADIUS_FULL);
		gap_pct = 0;
		stall_pct = 0;
		send_event(make_event(MODE_BEGIN, 4'd10, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MIN));
		send_event(make_event(MODE_UPDATE, ONE_TOUCH, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MAX, COORD_MIN, COORD_MAX));
		send_event(make_event(MODE_TICK, ONE_TOUCH, 0, 0, 0, 0, 0, 0));
		send_event(make_event(MODE_BEGIN, ONE_TOUCH, COORD_MAX, COORD_MIN, 0, 0,
			COORD_MIN, COORD_MIN));
		send_event(make_event(MODE_END, ONE_TOUCH, 3, 3, 0, 0, 3, 3));
		set_regs('0, RADIUS_FULL - 1'b1);
		send_event(make_event(MODE_UPDATE, ONE_TOUCH, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX));
		send_event(make_event(MODE_TICK, ONE_TOUCH, 0, 0, 0, 0, 0, 0));
		send_event(make_event(MODE_END, ONE_TOUCH, COORD_MAX, COORD_MAX, 0, 0,
			COORD_MIN, COORD_MIN));
		send_event(make_event(MODE_CLEAR, 4'd0, COORD_MIN, COORD_MIN, 0, 0, 0, 0));
		send_event(make_event(MODE_BEGIN, ONE_TOUCH, -5, 17, -5, 17, 40, 41));
		send_event(make_event(MODE_END, ONE_TOUCH, -6, 18, -5, 17, 42, 43));
		send_event(make_event(MODE_SPARE_MID, ONE_TOUCH, 1, 1, 1, 1, 1, 1));
	endtask

	task automatic run_sessions(int unsigned n_items);
		int unsigned goal;
		int unsigned pick;
		int unsigned burst;
		logic signed [CoordW-1:0] sx;
		logic signed [CoordW-1:0] sy;
		goal = sent_items + n_items;
		while (sent_items < goal) begin
			if ($urandom_range(0, 9) == 0) begin
				send_event(noise_event());
			end else begin
				sx = CoordW'($urandom);
				sy = CoordW'($urandom);
				send_event(make_event(MODE_BEGIN, pick_count(80), sx, sy, sx, sy,
					CoordW'($urandom), CoordW'($urandom)));
				repeat ($urandom_range(0, 4)) begin
					pick = $urandom_range(0, 9);
					if (pick < 6) begin
						send_event(moved_event(MODE_UPDATE, pick_count(90), sx, sy));
					end else if (pick < 9) begin
						burst = (hold_setting <= 4) ? hold_setting + 1 : 3;
						repeat ($urandom_range(1, burst))
							send_event(moved_event(MODE_TICK, pick_count(50), sx, sy));
					end else begin
						send_event(noise_event());
					end
				end
				send_event(moved_event(MODE_END, pick_count(85), sx, sy));
			end
		end
	endtask

	task automatic test_random_traffic();
		set_regs(17'd1, '0);
		gap_pct = 25;
		stall_pct = 25;
		run_sessions(250);
		set_regs(17'd2, 17'd40);
		gap_pct = 0;
		stall_pct = 30;
		run_sessions(250);
		set_regs('0, RADIUS_ONES);
		gap_pct = 30;
		stall_pct = 0;
		run_sessions(150);
		set_regs(HOLD_ONES, RADIUS_FULL);
		gap_pct = 15;
		stall_pct = 15;
		run_sessions(150);
		set_regs(HOLD_HIGHBIT, 17'd300);
		gap_pct = 20;
		stall_pct = 20;
		run_sessions(250);
	endtask

	task automatic test_full_rate();
		set_regs(17'd3, 17'd12);
		gap_pct = 0;
		stall_pct = 0;
		run_sessions(300);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_default_regs();
		test_register_extremes();
		test_random_traffic();
		test_full_rate();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
